>>> design/fphs_pkg.sv
// ----------------------------------------------------------------------------
// fphs_pkg
// Shared types and constants of the five-point heat stencil.
// ----------------------------------------------------------------------------
package fphs_pkg;

	localparam int SIDE_W   = 6;
	localparam int CMP_W    = SIDE_W + 1;
	localparam int SMP_W    = 16;
	localparam int WORD_W   = 2 * SMP_W;
	localparam int SUM_W    = 19;
	localparam int MUL_W    = 20;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [SIDE_W-1:0]  GRID_SIDE_RESET = 6'd32;
	localparam logic [PADDR_W-1:0] REG_GRID_SIDE   = 2'd0;

	// floor(v / 5) = (v * DIV5_MUL) >> DIV5_SHIFT for every v below 2**22
	localparam logic [MUL_W-1:0] DIV5_MUL   = 20'd838861;
	localparam int               DIV5_SHIFT = 22;
	localparam logic [SUM_W-1:0] ROUND_BIAS = 19'd2;

	typedef struct packed {
		logic has_up;
		logic has_left;
		logic has_right;
		logic down_center;
	} fphs_nbr_t;

endpackage

>>> design/fphs_ram.sv
// ----------------------------------------------------------------------------
// fphs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fphs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]                       rd_data_a,
	output logic [WIDTH-1:0]                       rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

>>> design/fphs_cfg.sv
// ----------------------------------------------------------------------------
// fphs_cfg
// Register port: holds grid_side, clamps it to a usable side, flags writes.
// ----------------------------------------------------------------------------
module fphs_cfg #(
	parameter int MAX_SIDE = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fphs_pkg::PADDR_W-1:0]  paddr,
	input  logic [fphs_pkg::PDATA_W-1:0]  pwdata,
	output logic [fphs_pkg::PDATA_W-1:0]  prdata,
	output logic [fphs_pkg::SIDE_W-1:0]   side,
	output logic                          restart
);
	import fphs_pkg::*;

	localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

	logic [SIDE_W-1:0] grid_side_q;
	logic              wr_hit;

	assign wr_hit  = psel && penable && pwrite && (paddr == REG_GRID_SIDE);
	assign restart = wr_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_SIDE_RESET;
		end else if (wr_hit) begin
			grid_side_q <= pwdata[SIDE_W-1:0];
		end
	end

	always_comb begin
		if (grid_side_q == '0) begin
			side = SIDE_W'(1);
		end else if (grid_side_q > MAX_SIDE_V) begin
			side = MAX_SIDE_V;
		end else begin
			side = grid_side_q;
		end
	end

	always_comb begin
		unique case (paddr)
			REG_GRID_SIDE: prdata = PDATA_W'(grid_side_q);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> design/fphs_gather.sv
// ----------------------------------------------------------------------------
// fphs_gather
// Picks the five stencil taps from row data, bypass, the left tap and the
// down input, applies the replicate border and forms the rounded sum.
// ----------------------------------------------------------------------------
module fphs_gather (
	input  logic [fphs_pkg::WORD_W-1:0] rd_a,
	input  logic [fphs_pkg::WORD_W-1:0] rd_b,
	input  logic                        byp_a,
	input  logic                        byp_b,
	input  logic [fphs_pkg::WORD_W-1:0] byp_data,
	input  logic [fphs_pkg::SMP_W-1:0]  prev_center,
	input  logic [fphs_pkg::SMP_W-1:0]  down_in,
	input  fphs_pkg::fphs_nbr_t         nbr,
	output logic [fphs_pkg::SMP_W-1:0]  center,
	output logic [fphs_pkg::SUM_W-1:0]  sum
);
	import fphs_pkg::*;

	logic [WORD_W-1:0] word_a;
	logic [WORD_W-1:0] word_b;
	logic [SMP_W-1:0]  up;
	logic [SMP_W-1:0]  left;
	logic [SMP_W-1:0]  right;
	logic [SMP_W-1:0]  down;

	assign word_a = byp_a ? byp_data : rd_a;
	assign word_b = byp_b ? byp_data : rd_b;

	assign center = word_a[WORD_W-1:SMP_W];
	assign up     = nbr.has_up      ? word_a[SMP_W-1:0]        : center;
	assign right  = nbr.has_right   ? word_b[WORD_W-1:SMP_W]   : center;
	assign left   = nbr.has_left    ? prev_center              : center;
	assign down   = nbr.down_center ? center                   : down_in;

	assign sum = SUM_W'(center) + SUM_W'(up) + SUM_W'(left) + SUM_W'(right)
		+ SUM_W'(down) + ROUND_BIAS;

endmodule

>>> design/fphs_div5.sv
// ----------------------------------------------------------------------------
// fphs_div5
// Divide by five through a reciprocal multiply.
// ----------------------------------------------------------------------------
module fphs_div5 (
	input  logic [fphs_pkg::SUM_W-1:0] sum,
	output logic [fphs_pkg::SMP_W-1:0] quotient
);
	import fphs_pkg::*;

	logic [SUM_W+MUL_W-1:0] prod;

	assign prod     = (SUM_W+MUL_W)'(sum) * (SUM_W+MUL_W)'(DIV5_MUL);
	assign quotient = prod[DIV5_SHIFT +: SMP_W];

endmodule

>>> design/five_point_heat_stencil.sv
// ----------------------------------------------------------------------------
// five_point_heat_stencil
// One Jacobi five-point sweep over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_stall, one per transfer, row by row. Each
// result on out_valid/out_stall is the rounded mean of a cell and its four
// neighbours, with a replicate border. Result (i,j) follows input (i+1,j);
// the first row gives no result. The last input of a frame also drains the
// whole final row: grid_side + 1 results (one for a one-cell grid), with
// frame_end on the last one. run_end marks the last result caused by one
// input. Each result passes the stage 1, stage 2 and output registers. One
// sample is taken per cycle while in_stall is low; the row RAM has a single
// write port and two read ports. The final-row drain holds in_stall high
// while it issues the final row. grid_side is written on the register port
// at byte address 0 and restarts the frame. After reset grid_side is 32 and
// the frame starts at row 0, column 0. A stalled output holds its result;
// the pipeline behind it keeps filling until full and then raises in_stall.
// ----------------------------------------------------------------------------
module five_point_heat_stencil #(
	parameter int MAX_SIDE = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fphs_pkg::PADDR_W-1:0]  paddr,
	input  logic [fphs_pkg::PDATA_W-1:0]  pwdata,
	output logic [fphs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fphs_pkg::SMP_W-1:0]    sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fphs_pkg::SMP_W-1:0]    averaged,
	output logic                          run_end,
	output logic                          frame_end
);
	import fphs_pkg::*;

	localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic [SIDE_W-1:0] side;
	logic              restart;
	logic [CMP_W-1:0]  side_x;

	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              drain_q;
	logic [IDX_W-1:0]  drain_col_q;

	logic              valid_s1;
	logic              emit_s1;
	logic              wr_s1;
	logic              run_end_s1;
	logic              frame_end_s1;
	logic [IDX_W-1:0]  col_s1;
	logic [SMP_W-1:0]  x_s1;
	fphs_nbr_t         nbr_s1;
	logic              byp_a_s1;
	logic              byp_b_s1;
	logic [WORD_W-1:0] byp_data_s1;
	logic [SMP_W-1:0]  prev_center_q;

	logic              valid_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              run_end_s2;
	logic              frame_end_s2;

	logic              out_valid_q;
	logic [SMP_W-1:0]  averaged_q;
	logic              run_end_q;
	logic              frame_end_q;

	logic              out_free;
	logic              s2_free;
	logic              s2_mv;
	logic              s1_mv;
	logic              s1_free;
	logic              in_acc;
	logic              drain_issue;
	logic              load_s1;

	logic              col_last;
	logic              row_last;
	logic              drain_last;
	logic [IDX_W-1:0]  issue_col;
	logic [IDX_W-1:0]  issue_col_p1;
	logic              right_ok;
	logic [IDX_W-1:0]  rd_addr_a;
	logic [IDX_W-1:0]  rd_addr_b;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd_data_a;
	logic [WORD_W-1:0] rd_data_b;
	logic [SMP_W-1:0]  center;
	logic [SUM_W-1:0]  sum;
	logic [SMP_W-1:0]  quotient;

	fphs_cfg #(
		.MAX_SIDE (MAX_SIDE)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.side    (side),
		.restart (restart)
	);

	assign pready = 1'b1;
	assign side_x = CMP_W'(side);

	// handshake and pipeline advance
	assign out_free    = !out_valid_q || !out_stall;
	assign s2_free     = !valid_s2 || out_free;
	assign s2_mv       = valid_s2 && out_free;
	assign s1_mv       = valid_s1 && (!emit_s1 || s2_free);
	assign s1_free     = !valid_s1 || s1_mv;
	assign in_stall    = drain_q || !s1_free;
	assign in_acc      = in_valid && !in_stall;
	assign drain_issue = drain_q && s1_free;
	assign load_s1     = in_acc || drain_issue;

	assign col_last   = (CMP_W'(col_q) + CMP_W'(1)) == side_x;
	assign row_last   = (CMP_W'(row_q) + CMP_W'(1)) == side_x;
	assign drain_last = (CMP_W'(drain_col_q) + CMP_W'(1)) == side_x;

	assign issue_col    = drain_q ? drain_col_q : col_q;
	assign issue_col_p1 = issue_col + IDX_W'(1);
	assign right_ok     = (CMP_W'(issue_col) + CMP_W'(1)) < side_x;
	assign rd_addr_a    = issue_col;
	assign rd_addr_b    = right_ok ? issue_col_p1 : issue_col;

	assign wr_en   = s1_mv && wr_s1;
	assign wr_data = {x_s1, center};

	fphs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_SIDE)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (col_s1),
		.wr_data   (wr_data),
		.rd_en     (load_s1),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	fphs_gather u_gather (
		.rd_a        (rd_data_a),
		.rd_b        (rd_data_b),
		.byp_a       (byp_a_s1),
		.byp_b       (byp_b_s1),
		.byp_data    (byp_data_s1),
		.prev_center (prev_center_q),
		.down_in     (x_s1),
		.nbr         (nbr_s1),
		.center      (center),
		.sum         (sum)
	);

	fphs_div5 u_div5 (
		.sum      (sum_s2),
		.quotient (quotient)
	);

	// frame position and final-row drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			drain_q     <= 1'b0;
			drain_col_q <= '0;
		end else if (restart) begin
			row_q       <= '0;
			col_q       <= '0;
			drain_q     <= 1'b0;
			drain_col_q <= '0;
		end else begin
			if (in_acc) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
				if (col_last && row_last) begin
					drain_q     <= 1'b1;
					drain_col_q <= '0;
				end
			end
			if (drain_issue) begin
				if (drain_last) begin
					drain_q <= 1'b0;
				end else begin
					drain_col_q <= drain_col_q + IDX_W'(1);
				end
			end
		end
	end

	// stage 1: row data read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_mv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			col_s1                <= issue_col;
			x_s1                  <= sample;
			byp_a_s1              <= wr_en && (col_s1 == rd_addr_a);
			byp_b_s1              <= wr_en && (col_s1 == rd_addr_b);
			byp_data_s1           <= wr_data;
			nbr_s1.has_left       <= issue_col != '0;
			nbr_s1.has_right      <= right_ok;
			nbr_s1.down_center    <= drain_q;
			if (drain_q) begin
				emit_s1          <= 1'b1;
				wr_s1            <= 1'b0;
				run_end_s1       <= drain_last;
				frame_end_s1     <= drain_last;
				nbr_s1.has_up    <= side_x >= CMP_W'(2);
			end else begin
				emit_s1          <= row_q != '0;
				wr_s1            <= 1'b1;
				run_end_s1       <= !(col_last && row_last);
				frame_end_s1     <= 1'b0;
				nbr_s1.has_up    <= CMP_W'(row_q) >= CMP_W'(2);
			end
		end
		if (s1_mv) begin
			prev_center_q <= center;
		end
	end

	// stage 2: rounded sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_mv && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_mv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_mv && emit_s1) begin
			sum_s2       <= sum;
			run_end_s2   <= run_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_mv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_mv) begin
			averaged_q  <= quotient;
			run_end_q   <= run_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign averaged  = averaged_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

endmodule

>>> dv/tb_five_point_heat_stencil.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_five_point_heat_stencil
// Self-checking bench for the five-point heat stencil.
// ----------------------------------------------------------------------------
// A directed table drives one-cell grids, clamped sides, saturated and
// alternating frames and a mid-frame restart. Random phases follow. They use
// small grids and partial frames at the largest side. A
// local model of the sweep predicts every result. Output transfers are
// checked in order, field by field. The sender works in bursts, the
// receiver stalls on a changing pattern, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_five_point_heat_stencil;
	import fphs_pkg::*;

	localparam int SIDE_CAP   = 32;
	localparam int SETTLE     = 8;
	localparam int QUIET_MAX  = 4000;
	localparam int SMALL_GOAL = 220;

	typedef struct packed {
		logic [SMP_W-1:0] averaged;
		logic             run_end;
		logic             frame_end;
	} cell_result_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_SAMPLE,
		ROW_ONE_CELL
	} stim_kind_t;

	typedef struct {
		stim_kind_t  kind;
		logic [31:0] value;
	} stim_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [SMP_W-1:0]   sample    = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SMP_W-1:0]   averaged;
	logic               run_end;
	logic               frame_end;

	five_point_heat_stencil #(
		.MAX_SIDE(SIDE_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.averaged (averaged),
		.run_end  (run_end),
		.frame_end(frame_end)
	);

	always #5 clk = ~clk;

	// sweep model state
	logic [SIDE_W-1:0] side_reg = GRID_SIDE_RESET;
	logic [SMP_W-1:0]  row_mem [2*SIDE_CAP];
	int unsigned       row_pos = 0;
	int unsigned       col_pos = 0;

	cell_result_t awaited_cells [$];
	cell_result_t new_cells [$];
	int           mismatches = 0;
	int           burst_left = 0;
	int           quiet_cycles = 0;

	stim_row_t dir_rows [29] = '{
		'{ROW_CFG,      32'hFFFF_FFC1},
		'{ROW_ONE_CELL, 32'h0000_0000},
		'{ROW_ONE_CELL, 32'h0000_FFFF},
		'{ROW_CFG,      32'h0000_0000},
		'{ROW_ONE_CELL, 32'h0000_A5C3},
		'{ROW_CFG,      32'h0000_0002},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_CFG,      32'h8000_0003},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_3039},
		'{ROW_SAMPLE,   32'h0000_D431},
		'{ROW_CFG,      32'h0000_0002},
		'{ROW_SAMPLE,   32'h0000_0064},
		'{ROW_SAMPLE,   32'h0000_0000},
		'{ROW_SAMPLE,   32'h0000_FFFF},
		'{ROW_SAMPLE,   32'h0000_0007}
	};

	function automatic int unsigned side_eff();
		int unsigned g;
		g = side_reg;
		if (g < 1) g = 1;
		if (g > SIDE_CAP) g = SIDE_CAP;
		return g;
	endfunction

	function automatic logic [SMP_W-1:0] cell_mean(int unsigned cb, int unsigned ub,
			bit has_up, int unsigned j, int unsigned n, int unsigned down);
		int unsigned center, left, right, up, total;
		center = row_mem[cb + j];
		left   = (j > 0) ? row_mem[cb + j - 1] : center;
		right  = (j + 1 < n) ? row_mem[cb + j + 1] : center;
		up     = has_up ? row_mem[ub + j] : center;
		total  = center + left + right + up + down;
		return SMP_W'((total + 2) / 5);
	endfunction

	function automatic void diffuse_sample(logic [SMP_W-1:0] x);
		int unsigned  n, r, c, nb, pb, j;
		cell_result_t res;
		n  = side_eff();
		r  = row_pos;
		c  = col_pos;
		nb = (r % 2) * SIDE_CAP;
		pb = ((r + 1) % 2) * SIDE_CAP;
		if (r >= n || c >= n) begin
			r  = 0;
			c  = 0;
			nb = 0;
			pb = SIDE_CAP;
		end
		if (r >= 1) begin
			res.averaged  = cell_mean(pb, nb, r >= 2, c, n, x);
			res.run_end   = 1'b0;
			res.frame_end = 1'b0;
			new_cells.push_back(res);
		end
		row_mem[nb + c] = x;
		if (r == n - 1 && c == n - 1) begin
			for (j = 0; j < n; j++) begin
				res.averaged  = cell_mean(nb, pb, n >= 2, j, n, row_mem[nb + j]);
				res.run_end   = 1'b0;
				res.frame_end = (j == n - 1);
				new_cells.push_back(res);
			end
		end
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n) r = 0;
		end
		row_pos = r;
		col_pos = c;
		if (new_cells.size() > 0) begin
			res = new_cells.pop_back();
			res.run_end = 1'b1;
			new_cells.push_back(res);
		end
	endfunction

	function automatic logic [SMP_W-1:0] pick_value(int mode, logic [SMP_W-1:0] base);
		case (mode)
			0: return SMP_W'($urandom_range(0, 65535));
			1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			2: return base + SMP_W'($urandom_range(0, 255));
			default: return ($urandom_range(0, 1) != 0) ? SMP_W'($urandom_range(0, 31))
					: SMP_W'(65535 - $urandom_range(0, 31));
		endcase
	endfunction

	// hold valid low until every awaited result is out, then let the pipe settle
	task automatic drain_wait();
		in_valid <= 1'b0;
		while (awaited_cells.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_sample(logic [SMP_W-1:0] v, bit one_cell);
		cell_result_t res;
		int           gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (in_stall);
		new_cells.delete();
		diffuse_sample(v);
		if (one_cell) begin
			res.averaged  = v;
			res.run_end   = 1'b1;
			res.frame_end = 1'b1;
			awaited_cells.push_back(res);
		end else begin
			foreach (new_cells[k]) awaited_cells.push_back(new_cells[k]);
		end
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_side(logic [31:0] word);
		drain_wait();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_GRID_SIDE;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		side_reg = word[SIDE_W-1:0];
		row_pos  = 0;
		col_pos  = 0;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(side_reg)) begin
			$error("prdata: expected %h, got %h", PDATA_W'(side_reg), prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] side_word(int unsigned side);
		logic [31:0] word;
		word = $urandom();
		word[SIDE_W-1:0] = SIDE_W'(side);
		return word;
	endfunction

	// receiver stall pattern
	int stall_mode = 0;
	int stall_span = 0;
	int stall_tick = 0;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(8, 80);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_tick % 3 == 0);
		endcase
		stall_tick++;
	end

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_cells.size() == 0) begin
				$error("averaged: expected nothing, got %h", averaged);
				mismatches++;
			end else begin
				want = awaited_cells.pop_front();
				if (averaged !== want.averaged) begin
					$error("averaged: expected %h, got %h", want.averaged, averaged);
					mismatches++;
				end
				if (run_end !== want.run_end) begin
					$error("run_end: expected %b, got %b", want.run_end, run_end);
					mismatches++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end: expected %b, got %b", want.frame_end, frame_end);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n, count, side, small_items;
		int          vmode, pause_at;
		logic [SMP_W-1:0] base;
		small_items = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG:      write_side(dir_rows[i].value);
				ROW_ONE_CELL: send_sample(dir_rows[i].value[SMP_W-1:0], 1'b1);
				default:      send_sample(dir_rows[i].value[SMP_W-1:0], 1'b0);
			endcase
		end

		// largest side: partial frames, clamped from 63 and then at 32
		write_side(side_word(63));
		vmode = 0;
		for (int k = 0; k < 3 * SIDE_CAP; k++) begin
			if (k % 32 == 0) vmode = $urandom_range(0, 3);
			send_sample(pick_value(vmode, SMP_W'($urandom())), 1'b0);
		end
		write_side(side_word(32));
		count = $urandom_range(33, 90);
		for (int k = 0; k < count; k++) send_sample(pick_value(0, '0), 1'b0);

		while (small_items < SMALL_GOAL) begin
			if (small_items == 0 || $urandom_range(0, 3) != 0) begin
				side = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
						: $urandom_range(0, 9);
				write_side(side_word(side));
			end
			n = side_eff();
			if (n > 9)
				count = $urandom_range(n, 3 * n);
			else if ($urandom_range(0, 9) < 7)
				count = n * n * $urandom_range(1, 2);
			else
				count = $urandom_range(1, n * n);
			vmode    = $urandom_range(0, 3);
			base     = SMP_W'($urandom());
			pause_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, count - 1)) : -1;
			for (int k = 0; k < count; k++) begin
				if (k == pause_at) drain_wait();
				send_sample(pick_value(vmode, base), 1'b0);
				small_items++;
			end
		end

		in_valid <= 1'b0;
		while (awaited_cells.size() != 0) @(posedge clk);
		repeat (4 * SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
